### hdl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern search block.
// Used by wbps_cfg, wbps_cell and wildcard_byte_pattern_search; no dependencies.
package wbps_pkg;

    // Fixed field widths.
    localparam int DATA_W    = 8;
    localparam int ADDR_W    = 48;
    localparam int LEN_W     = 5;
    localparam int WORD_W    = 64;
    localparam int MASK_W    = 16;
    localparam int BIDX_W    = 4;
    localparam int CFG_IDX_W = 3;

    // Default and upper bound of the pattern length.
    localparam int MAX_PATTERN_BYTES_DEF = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_LOW    = 3'd1,
        CFG_PATTERN_HIGH   = 3'd2,
        CFG_WILDCARD_MASK  = 3'd3,
        CFG_FIND_ALL       = 3'd4
    } cfg_index_t;

    // Control settings handed from the register file to the scan logic.
    typedef struct packed {
        logic [LEN_W-1:0] active_len;
        logic             find_all;
    } cfg_ctl_t;

endpackage

### hdl/wbps_cfg.sv
// Configuration registers and per-cell compare settings of the pattern search.
// Depends on wbps_pkg.
module wbps_cfg #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wbps_pkg::WORD_W-1:0]           cfg_data,
    output wbps_pkg::cfg_ctl_t                    ctl,
    output logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::DATA_W-1:0] cell_expect,
    output logic [MAX_PATTERN_BYTES-1:0]          cell_care
);

    logic [wbps_pkg::LEN_W-1:0]  length_reg;
    logic [wbps_pkg::WORD_W-1:0] pat_low_reg;
    logic [wbps_pkg::WORD_W-1:0] pat_high_reg;
    logic [wbps_pkg::MASK_W-1:0] mask_reg;
    logic                        find_all_reg;
    logic [wbps_pkg::LEN_W-1:0]  len_act;
    logic [2*wbps_pkg::WORD_W-1:0] pattern;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg   <= wbps_pkg::LEN_W'(1);
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            mask_reg     <= '0;
            find_all_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                wbps_pkg::CFG_PATTERN_LENGTH: length_reg <= cfg_data[wbps_pkg::LEN_W-1:0];
                wbps_pkg::CFG_PATTERN_LOW:    pat_low_reg <= cfg_data;
                wbps_pkg::CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                wbps_pkg::CFG_WILDCARD_MASK:  mask_reg <= cfg_data[wbps_pkg::MASK_W-1:0];
                wbps_pkg::CFG_FIND_ALL:       find_all_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the length into 1..MAX_PATTERN_BYTES.
    always_comb begin
        if (length_reg == '0) begin
            len_act = wbps_pkg::LEN_W'(1);
        end else if (length_reg > wbps_pkg::LEN_W'(MAX_PATTERN_BYTES)) begin
            len_act = wbps_pkg::LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            len_act = length_reg;
        end
    end

    assign pattern        = {pat_high_reg, pat_low_reg};
    assign ctl.active_len = len_act;
    assign ctl.find_all   = find_all_reg;

    // Window entry i lines up with pattern byte len-1-i; entries past the
    // length are don't-care.
    for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_sel
        logic [wbps_pkg::LEN_W-1:0]  pos_full;
        logic [wbps_pkg::BIDX_W-1:0] pos;
        assign pos_full       = len_act - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(i);
        assign pos            = pos_full[wbps_pkg::BIDX_W-1:0];
        assign cell_expect[i] = pattern[pos*wbps_pkg::DATA_W +: wbps_pkg::DATA_W];
        assign cell_care[i]   = (wbps_pkg::LEN_W'(i) < len_act) && !mask_reg[pos];
    end

endmodule

### hdl/wbps_cell.sv
// One window cell: holds a byte, passes it to its neighbor on each shift and
// compares the byte it is about to take. Depends on wbps_pkg.
module wbps_cell (
    input  logic                        aclk,
    input  logic                        shift_en,
    input  logic [wbps_pkg::DATA_W-1:0] in_byte,
    input  logic [wbps_pkg::DATA_W-1:0] expect_byte,
    input  logic                        care,
    output logic [wbps_pkg::DATA_W-1:0] out_byte,
    output logic                        match
);

    logic [wbps_pkg::DATA_W-1:0] byte_reg;

    // Window storage; its contents only count once the fill count covers it.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= in_byte;
        end
    end

    assign out_byte = byte_reg;
    // The compare looks at the byte this cell will hold after the shift.
    assign match    = !care || (in_byte == expect_byte);

endmodule

### hdl/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search: a row of window cells compared in parallel.
// A result is written to the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle; the whole row is compared at once, combinationally.
// A byte is taken whenever the output register is empty or being drained.
// Reset (aresetn low, synchronous) clears the scan state, the output valid and
// the registers to length 1, zero pattern, no wildcards, find-first mode.
module wildcard_byte_pattern_search #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wbps_pkg::WORD_W-1:0]          cfg_data,
    // Input bytes.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [55:0]                          s_tdata,  // data_byte[7:0], byte_address[55:8]
    input  logic [0:0]                           s_tuser,  // section_start[0]
    input  logic                                 s_tlast,  // scan_end
    // Results.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [47:0]                          m_tdata,  // match_address[47:0]
    output logic [0:0]                           m_tuser,  // found[0]
    output logic                                 m_tlast   // last
);

    localparam int N = MAX_PATTERN_BYTES;

    wbps_pkg::cfg_ctl_t                       ctl;
    logic [N-1:0][wbps_pkg::DATA_W-1:0]       cell_expect;
    logic [N-1:0]                             cell_care;
    logic [N:0][wbps_pkg::DATA_W-1:0]         chain;
    logic [N-1:0]                             cell_match;

    logic [wbps_pkg::LEN_W-1:0]  fill_count_reg, fill_count_next;
    logic                        first_done_reg, first_done_next;
    logic                        m_valid_reg, m_valid_next;
    logic [wbps_pkg::ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic                        m_found_reg, m_found_next;
    logic                        m_last_reg, m_last_next;

    logic [wbps_pkg::DATA_W-1:0] in_byte;
    logic [wbps_pkg::ADDR_W-1:0] in_addr;
    logic                        sec_start, scan_end;
    logic                        accept, skip, shift_en, hit, produce;
    logic [wbps_pkg::LEN_W-1:0]  fill_base, fill_new;

    assign in_byte   = s_tdata[7:0];
    assign in_addr   = s_tdata[55:8];
    assign sec_start = s_tuser[0];
    assign scan_end  = s_tlast;

    wbps_cfg #(
        .MAX_PATTERN_BYTES(N)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ctl        (ctl),
        .cell_expect(cell_expect),
        .cell_care  (cell_care)
    );

    // Row of window cells, newest byte entering cell 0.
    assign chain[0] = in_byte;
    for (genvar i = 0; i < N; i++) begin : g_cell
        wbps_cell u_cell (
            .aclk       (aclk),
            .shift_en   (shift_en),
            .in_byte    (chain[i]),
            .expect_byte(cell_expect[i]),
            .care       (cell_care[i]),
            .out_byte   (chain[i+1]),
            .match      (cell_match[i])
        );
    end

    // Handshake: the output register frees up as it drains.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Once find-first mode has reported, bytes are dropped until the scan end.
    assign skip     = !ctl.find_all && first_done_reg;
    assign shift_en = accept && !skip;

    // Fill count restarts on a section start and saturates at the row length.
    assign fill_base = sec_start ? '0 : fill_count_reg;
    assign fill_new  = (fill_base < wbps_pkg::LEN_W'(N)) ?
                       fill_base + wbps_pkg::LEN_W'(1) : fill_base;

    assign hit     = !skip && (fill_new >= ctl.active_len) && (&cell_match);
    assign produce = accept && !skip && (hit || scan_end);

    // Scan state and output register.
    always_comb begin
        fill_count_next = fill_count_reg;
        first_done_next = first_done_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_addr_next     = m_addr_reg;
        m_found_next    = m_found_reg;
        m_last_next     = m_last_reg;
        if (accept) begin
            if (scan_end) begin
                fill_count_next = '0;
                first_done_next = 1'b0;
            end else if (!skip) begin
                fill_count_next = fill_new;
                if (hit && !ctl.find_all) begin
                    first_done_next = 1'b1;
                end
            end
        end
        if (produce) begin
            m_valid_next = 1'b1;
            m_found_next = hit;
            m_last_next  = !ctl.find_all || scan_end;
            m_addr_next  = hit ?
                           in_addr - wbps_pkg::ADDR_W'(ctl.active_len - wbps_pkg::LEN_W'(1)) :
                           '0;
            if (!hit) begin
                m_last_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            first_done_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            first_done_reg <= first_done_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_addr_reg  <= m_addr_next;
        m_found_reg <= m_found_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_addr_reg;
    assign m_tuser[0] = m_found_reg;
    assign m_tlast    = m_last_reg;

    // The fill count never passes the row length.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= wbps_pkg::LEN_W'(N))
        else $error("fill count beyond window length");

    // The window is frozen while find-first mode waits for the scan end.
    a_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (first_done_reg && !ctl.find_all) |-> !shift_en)
        else $error("window shifted after first match");

    // A result without a match carries address zero and closes the scan.
    a_miss_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0) && m_tlast)
        else $error("miss result malformed");

    // A find-first match sets the done flag on the following cycle.
    a_first_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && hit && !ctl.find_all && !scan_end) |=> first_done_reg)
        else $error("first match not recorded");

endmodule

### tb/sv/wbps_match_sb_pkg.sv
`timescale 1ns / 1ps
// Match scoreboard for the wildcard byte pattern search testbench.
// Predicts the scan results of every accepted byte and checks the block's results in order.
// Depends on wbps_pkg for the register indexes.
package wbps_match_sb_pkg;

    import wbps_pkg::*;

    // One scan result as the block should present it.
    typedef struct {
        logic [47:0] match_address;
        bit          found;
        bit          is_last;
    } scan_result_t;

    class match_scoreboard;

        scan_result_t expected_results[$];
        int           errors;

        // Register copies.
        logic [4:0]   len_reg;
        logic [127:0] pattern;
        logic [15:0]  wild_mask;
        bit           find_all;

        // Scan state.
        logic [7:0]   window [16];
        int unsigned  fill;
        bit           first_done;
        bit           any_found;

        function new();
            len_reg    = 5'd1;
            pattern    = '0;
            wild_mask  = '0;
            find_all   = 1'b0;
            foreach (window[i]) window[i] = '0;
            fill       = 0;
            first_done = 1'b0;
            any_found  = 1'b0;
            errors     = 0;
        endfunction

        // Mirror a register write request accepted by the block.
        function void write_reg(cfg_index_t idx, logic [63:0] value);
            case (idx)
                CFG_PATTERN_LENGTH: len_reg = value[4:0];
                CFG_PATTERN_LOW:    pattern[63:0] = value;
                CFG_PATTERN_HIGH:   pattern[127:64] = value;
                CFG_WILDCARD_MASK:  wild_mask = value[15:0];
                CFG_FIND_ALL:       find_all = value[0];
                default: ;
            endcase
        endfunction

        // True when the next byte is dropped because find-first already hit.
        function bit ignoring();
            return !find_all && first_done;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void clear_scan();
            fill       = 0;
            first_done = 1'b0;
            any_found  = 1'b0;
        endfunction

        // Work out the result, if any, caused by one accepted byte request.
        function void predict_byte(logic [7:0] data, logic [47:0] addr, bit sec, bit fin);
            int unsigned  len;
            bit           hit;
            scan_result_t res;

            len = (len_reg == 0) ? 1 : ((len_reg > 16) ? 16 : len_reg);

            if (ignoring()) begin
                if (fin) clear_scan();
                return;
            end

            for (int i = 15; i > 0; i--) window[i] = window[i - 1];
            window[0] = data;
            if (sec) fill = 0;
            if (fill < 16) fill++;

            // Oldest byte of the window lines up with pattern byte 0.
            hit = (fill >= len);
            for (int i = 0; i < len; i++) begin
                if (!wild_mask[i] && window[len - 1 - i] != pattern[8 * i +: 8]) hit = 1'b0;
            end

            if (hit) begin
                res.match_address = addr - 48'(len - 1);
                res.found         = 1'b1;
                res.is_last       = !find_all || fin;
                expected_results.insert(expected_results.size(), res);
                any_found = 1'b1;
                if (!find_all) first_done = 1'b1;
            end else if (fin) begin
                res.match_address = '0;
                res.found         = 1'b0;
                res.is_last       = 1'b1;
                expected_results.insert(expected_results.size(), res);
            end

            if (fin) clear_scan();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest expectation.
        task check_result(logic [47:0] match_address, logic found, logic is_last);
            scan_result_t exp_res;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result addr=%h found=%b last=%b",
                                          match_address, found, is_last));
                return;
            end
            exp_res = expected_results.pop_front();
            if (match_address !== exp_res.match_address)
                report_mismatch($sformatf("match_address %h, expected %h",
                                          match_address, exp_res.match_address));
            if (found !== exp_res.found)
                report_mismatch($sformatf("found %b, expected %b", found, exp_res.found));
            if (is_last !== exp_res.is_last)
                report_mismatch($sformatf("last %b, expected %b", is_last, exp_res.is_last));
        endtask

    endclass

endpackage

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench of wildcard_byte_pattern_search: directed and random byte scans
// under several pattern settings, checked against the match scoreboard.
// Depends on wbps_pkg and wbps_match_sb_pkg.
module testbench;

    import wbps_pkg::*;
    import wbps_match_sb_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // data_byte[7:0], byte_address[55:8]
    logic [0:0]  s_tuser;   // section_start[0]
    logic        s_tlast;   // scan_end
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // match_address[47:0]
    logic [0:0]  m_tuser;   // found[0]
    logic        m_tlast;   // last

    match_scoreboard sb = new();

    // Stimulus settings shared between processes.
    int           src_idle_pct  = 0;
    int           sink_idle_pct = 0;
    bit           hold_request  = 1'b0;
    bit           sink_hold     = 1'b0;
    int           cur_len       = 1;
    logic [127:0] cur_pattern   = '0;
    logic [15:0]  cur_wild      = '0;
    bit           cur_find_all  = 1'b0;
    logic [47:0]  cur_addr      = '0;

    wildcard_byte_pattern_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin : clock_gen
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog for a hung run.
    initial begin : watchdog
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, forced low during a hold-off.
    initial begin : result_sink
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= !sink_hold && ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Long receiver hold-off so the block fills up and stalls its input.
    initial begin : sink_hold_off
        wait (hold_request);
        sink_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    // Check every result request taken from the block.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0], m_tlast);
    end

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_register(cfg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    task automatic program_search(logic [4:0] len_reg, logic [63:0] lo, logic [63:0] hi,
                                  logic [15:0] mask, bit all);
        write_register(CFG_PATTERN_LENGTH, 64'(len_reg));
        write_register(CFG_PATTERN_LOW, lo);
        write_register(CFG_PATTERN_HIGH, hi);
        write_register(CFG_WILDCARD_MASK, 64'(mask));
        write_register(CFG_FIND_ALL, 64'(all));
        cfg_valid    <= 1'b0;
        cur_len      = (len_reg == 0) ? 1 : ((len_reg > 16) ? 16 : int'(len_reg));
        cur_pattern  = {hi, lo};
        cur_wild     = mask;
        cur_find_all = all;
    endtask

    // Offer one byte request; each cycle ahead of it the sender idles at the set rate.
    task automatic send_byte(logic [7:0] data, logic [47:0] addr, bit sec, bit fin);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {addr, data};
        s_tuser  <= sec;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        sb.predict_byte(data, addr, sec, fin);
    endtask

    // Drop the input and wait until every expected result has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Random byte, half of the time taken from the active pattern.
    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 0) return 8'($urandom);
        return cur_pattern[8 * $urandom_range(0, cur_len - 1) +: 8];
    endfunction

    // Send one scan byte with random address jumps, section starts and scan ends.
    task automatic send_scan_byte(logic [7:0] data, ref int counted);
        int r;
        bit sec;
        bit fin;
        r = $urandom_range(0, 99);
        if (r < 2)
            cur_addr = 48'({$urandom, $urandom});
        else if (r < 4)
            cur_addr = $urandom_range(0, 1) ? 48'($urandom_range(0, 20))
                                            : ~48'($urandom_range(0, 20));
        sec = ($urandom_range(0, 99) < 3);
        fin = ($urandom_range(0, 99) < (cur_find_all ? 3 : 6));
        counted++;
        send_byte(data, cur_addr, sec, fin);
        cur_addr = cur_addr + 48'd1;
    endtask

    // Mostly whole pattern copies with random wildcard content, some spoiled,
    // mixed with noise runs.
    task automatic run_random(int n_items);
        int         counted;
        int         pos;
        bit         spoil;
        logic [7:0] b;
        counted = 0;
        while (counted < n_items) begin
            if ($urandom_range(0, 99) < 60) begin
                repeat ($urandom_range(0, 3)) send_scan_byte(noise_byte(), counted);
                spoil = ($urandom_range(0, 99) < 20);
                pos   = $urandom_range(0, cur_len - 1);
                for (int i = 0; i < cur_len; i++) begin
                    b = cur_wild[i] ? 8'($urandom) : cur_pattern[8 * i +: 8];
                    if (spoil && i == pos) b = b ^ (8'd1 << $urandom_range(0, 7));
                    send_scan_byte(b, counted);
                end
            end else begin
                repeat ($urandom_range(1, 6)) send_scan_byte(noise_byte(), counted);
            end
        end
    endtask

    initial begin : stimulus
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Three-byte pattern AB ?? CD in find-all mode; bytes and wildcard bits
        // past the length are deliberately nonzero.
        program_search(5'd3, 64'h0123_4567_89CD_5AAB, 64'hFFFF_FFFF_FFFF_FFFF,
                       16'hFFFA, 1'b1);
        send_byte(8'hAB, 48'd0, 1'b1, 1'b0);
        send_byte(8'h00, 48'd1, 1'b0, 1'b0);
        send_byte(8'hCD, 48'd2, 1'b0, 1'b0);
        send_byte(8'hFF, 48'd3, 1'b0, 1'b0);
        // Match start address wraps below zero.
        send_byte(8'hAB, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_byte(8'hFF, 48'd0, 1'b0, 1'b0);
        send_byte(8'hCD, 48'd1, 1'b0, 1'b0);
        // A section start on the last pattern byte breaks the match.
        send_byte(8'hAB, 48'd10, 1'b0, 1'b0);
        send_byte(8'h12, 48'd11, 1'b0, 1'b0);
        send_byte(8'hCD, 48'd12, 1'b1, 1'b0);
        // Match completing on the scan end byte.
        send_byte(8'hAB, 48'd13, 1'b0, 1'b0);
        send_byte(8'h34, 48'd14, 1'b0, 1'b0);
        send_byte(8'hCD, 48'd15, 1'b0, 1'b1);
        // Scan ends with nothing matching on those bytes.
        send_byte(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1);
        send_byte(8'h00, 48'd0, 1'b0, 1'b1);
        settle();

        // Length register zero acts as one; find-first drops the rest of the scan.
        program_search(5'd0, 64'hA5A5_A5A5_A5A5_A5FF, 64'h0, 16'hFFFE, 1'b0);
        send_byte(8'h00, 48'd100, 1'b1, 1'b0);
        send_byte(8'hFF, 48'd101, 1'b0, 1'b0);
        send_byte(8'hFF, 48'd102, 1'b0, 1'b0);
        send_byte(8'h00, 48'd103, 1'b0, 1'b1);
        send_byte(8'h00, 48'd104, 1'b0, 1'b0);
        send_byte(8'hFF, 48'd105, 1'b0, 1'b1);
        send_byte(8'h00, 48'd106, 1'b0, 1'b1);
        settle();

        // Sender idles lightly, receiver heavily, with one long hold-off.
        src_idle_pct  = 34;
        sink_idle_pct = 74;
        program_search(5'd31, {$urandom, $urandom}, {$urandom, $urandom},
                       16'($urandom) & 16'($urandom), 1'b1);
        hold_request = 1'b1;
        run_random(120);
        settle();
        program_search(5'd5, {$urandom, $urandom}, {$urandom, $urandom},
                       16'($urandom), 1'b1);
        run_random(110);
        settle();

        // Sender idles heavily, receiver lightly.
        src_idle_pct  = 74;
        sink_idle_pct = 34;
        program_search(5'd0, {$urandom, $urandom}, {$urandom, $urandom},
                       16'($urandom), 1'b0);
        run_random(60);
        settle();
        program_search(5'd16, 64'h0, 64'h0, 16'h0000, 1'b0);
        run_random(60);
        settle();
        program_search(5'($urandom_range(1, 16)), {$urandom, $urandom},
                       {$urandom, $urandom}, 16'($urandom) & 16'($urandom), 1'b0);
        run_random(110);
        settle();

        // No idling on either side.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        program_search(5'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                       16'hFFFF, 1'b1);
        run_random(60);
        settle();
        program_search(5'd16, {$urandom, $urandom}, {$urandom, $urandom},
                       16'hFFFF, 1'b0);
        run_random(40);
        settle();
        program_search(5'($urandom_range(1, 16)), {$urandom, $urandom},
                       {$urandom, $urandom}, 16'($urandom) & 16'($urandom), 1'b1);
        run_random(140);
        settle();

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
hdl/wbps_pkg.sv
hdl/wbps_cfg.sv
hdl/wbps_cell.sv
hdl/wildcard_byte_pattern_search.sv
tb/sv/wbps_match_sb_pkg.sv
tb/sv/testbench.sv
